// ===== rtl/core/ppsc_pkg.sv =====
// ============================================================================
// ppsc_pkg - shared types and constants
// Constants, opcodes and queue entry type for the per-pixel separable filter.
// ============================================================================
package ppsc_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_KERNEL = 15;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int ADDR_W  = COL_W + ROW_W;
	localparam int KIDX_W  = $clog2(MAX_KERNEL);
	localparam int WCNT_W  = $clog2(2 * MAX_KERNEL + 1);
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_KERNEL = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_WEIGHT = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0, // write frame store
		CMD_HWT    = 2'd1, // write row weight
		CMD_VWT    = 2'd2  // vertical tap: walk the row
	} cmd_kind_t;

	// One classified request handed from the front to the back end.
	typedef struct packed {
		cmd_kind_t                kind;
		logic signed [15:0]       value;
		logic [ADDR_W-1:0]        addr;      // sample address
		logic [KIDX_W-1:0]        widx;      // row weight index
		logic [ROW_W-1:0]         out_row;
		logic [COL_W-1:0]         out_col;
		logic [COL_W:0]           width;     // effective width
		logic [ROW_W:0]           height;
		logic [KIDX_W:0]          ksize;
		logic                     row_ok;    // tap row inside the image
		logic [ROW_W-1:0]         tap_row;
		logic                     first_tap;
		logic                     last_tap;
		logic                     last_pixel;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_WALK = 2'd1,
		BK_ACC  = 2'd2,
		BK_OUT  = 2'd3
	} bk_state_t;

endpackage

// ===== rtl/core/ppsc_stream_if.sv =====
// ============================================================================
// ppsc_stream_if - valid/ready channel
// Carries one request per accepted handshake.
// ============================================================================
interface ppsc_stream_if #(parameter int W = 17);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ppsc_ram.sv =====
// ============================================================================
// ppsc_ram - generic single-port-write, registered-read RAM
// One write and one read address per cycle.
// ============================================================================
module ppsc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/ppsc_front.sv =====
// ============================================================================
// ppsc_front - request classifier
// Tracks load/compute phase and counters, turns each request into a command.
// ============================================================================
module ppsc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ppsc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ppsc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       in_op,
	input  logic [15:0]                in_value,
	output logic                       cmd_push,
	output ppsc_pkg::cmd_t             cmd,
	input  logic                       q_full
);
	import ppsc_pkg::*;

	logic [8:0] width_q, height_q;
	logic [3:0] ksize_q;
	logic [ADDR_W:0] load_idx_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [WCNT_W-1:0] wcnt_q;
	logic compute_q;

	logic [COL_W:0] w_eff;
	logic [ROW_W:0] h_eff;
	logic [KIDX_W:0] k_eff;
	logic [KIDX_W-1:0] pad;
	logic [WCNT_W-1:0] tap;
	logic signed [ROW_W+2:0] tap_row_s;
	logic take, last_pix, wrap_col, load_done;

	always_comb begin
		w_eff = (width_q == '0) ? (COL_W+1)'(1) :
			(width_q > 9'(MAX_WIDTH)) ? (COL_W+1)'(MAX_WIDTH) : (COL_W+1)'(width_q);
		h_eff = (height_q == '0) ? (ROW_W+1)'(1) :
			(height_q > 9'(MAX_HEIGHT)) ? (ROW_W+1)'(MAX_HEIGHT) : (ROW_W+1)'(height_q);
		k_eff = (ksize_q == '0) ? (KIDX_W+1)'(1) :
			(ksize_q > 4'(MAX_KERNEL)) ? (KIDX_W+1)'(MAX_KERNEL) : (KIDX_W+1)'(ksize_q);
		pad = KIDX_W'((k_eff - 1'b1) >> 1);
		tap = wcnt_q - WCNT_W'(k_eff);
		tap_row_s = $signed({3'b000, row_q}) - $signed({3'b000, pad})
			+ $signed({1'b0, (ROW_W+2)'(tap)});
	end

	assign in_ready = !q_full;
	assign take = in_valid && in_ready;
	assign wrap_col = (COL_W+1)'(col_q) + 1'b1 >= w_eff;
	assign last_pix = wrap_col && ((ROW_W+1)'(row_q) + 1'b1 >= h_eff);
	assign load_done = (load_idx_q + 1'b1) >= (ADDR_W+1)'(w_eff * h_eff);

	always_comb begin
		cmd = '0;
		cmd.value   = $signed(in_value);
		cmd.addr    = load_idx_q[ADDR_W-1:0];
		cmd.widx    = KIDX_W'(wcnt_q);
		cmd.out_row = row_q;
		cmd.out_col = col_q;
		cmd.width   = w_eff;
		cmd.height  = h_eff;
		cmd.ksize   = k_eff;
		cmd.tap_row = tap_row_s[ROW_W-1:0];
		cmd.row_ok  = !tap_row_s[ROW_W+2] && (tap_row_s < $signed({2'b00, h_eff}));
		cmd.first_tap  = wcnt_q == WCNT_W'(k_eff);
		cmd.last_tap   = wcnt_q + 1'b1 == WCNT_W'({k_eff, 1'b0});
		cmd.last_pixel = last_pix;
		cmd_push = 1'b0;
		if (take) begin
			if (!compute_q && in_op == OP_SAMPLE) begin
				cmd.kind = CMD_SAMPLE;
				cmd_push = 1'b1;
			end else if (compute_q && in_op == OP_WEIGHT) begin
				cmd.kind = (wcnt_q < WCNT_W'(k_eff)) ? CMD_HWT : CMD_VWT;
				cmd_push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd256; height_q <= 9'd256; ksize_q <= 4'd3;
			load_idx_q <= '0; col_q <= '0; row_q <= '0; wcnt_q <= '0;
			compute_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_KERNEL: ksize_q  <= cfg_data[3:0];
				default: ;
			endcase
			if (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT || cfg_idx == REG_KERNEL) begin
				load_idx_q <= '0; col_q <= '0; row_q <= '0; wcnt_q <= '0;
				compute_q <= 1'b0;
			end
		end else if (cmd_push) begin
			if (!compute_q) begin
				load_idx_q <= load_idx_q + 1'b1;
				if (load_done) begin
					compute_q <= 1'b1; col_q <= '0; row_q <= '0; wcnt_q <= '0;
				end
			end else if (cmd.last_tap && cmd.kind == CMD_VWT) begin
				wcnt_q <= '0;
				if (last_pix) begin
					compute_q <= 1'b0; load_idx_q <= '0; col_q <= '0; row_q <= '0;
				end else if (wrap_col) begin
					col_q <= '0; row_q <= row_q + 1'b1;
				end else
					col_q <= col_q + 1'b1;
			end else
				wcnt_q <= wcnt_q + 1'b1;
		end
	end

	// Weight counter never passes the vertical taps.
	assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q < WCNT_W'(2 * MAX_KERNEL))
		else $error("weight counter overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> in_valid && in_ready)
		else $error("push without request");
	assert property (@(posedge clk) disable iff (!arst_n)
		!compute_q |-> wcnt_q == '0)
		else $error("weights counted while loading");
endmodule

// ===== rtl/core/ppsc_queue.sv =====
// ============================================================================
// ppsc_queue - command FIFO
// Four-entry queue between classifier and execution unit.
// ============================================================================
module ppsc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ppsc_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output ppsc_pkg::cmd_t head
);
	import ppsc_pkg::*;

	cmd_t slot_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign full = cnt_q == 3'd4;
	assign not_empty = cnt_q != '0;
	assign head = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("queue underflow");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("queue count out of range");
endmodule

// ===== rtl/core/ppsc_back.sv =====
// ============================================================================
// ppsc_back - execution unit
// Writes samples and weights, walks the row taps one MAC per cycle.
// ============================================================================
module ppsc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_not_empty,
	input  ppsc_pkg::cmd_t q_head,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [15:0]    out_pixel,
	output logic           out_last
);
	import ppsc_pkg::*;

	bk_state_t state_q, state_d;
	cmd_t cur_q;
	logic signed [15:0] rw_q [MAX_KERNEL];
	logic [KIDX_W:0] j_q;          // tap issue count
	logic signed [COL_W+1:0] c_s;
	logic rd_ok, rd_en;
	logic rd_ok_s1, rd_v_s1, rd_v_s2;
	logic [KIDX_W-1:0] j_s1;
	logic [15:0] ram_rd;
	logic signed [15:0] samp_s2, wt_s2;
	logic signed [31:0] prod_s3;
	logic prod_v_s3;
	logic signed [39:0] rsum_q;
	logic signed [56:0] vprod_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] acc_r;
	logic signed [39:0] qv;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;
	logic [KIDX_W-1:0] pad;
	logic [2:0] drain_q;
	logic out_v_q;
	logic [15:0] pix_q;
	logic last_q;

	assign pad = KIDX_W'((cur_q.ksize - 1'b1) >> 1);
	assign c_s = $signed({2'b00, cur_q.out_col}) - $signed({2'b00, pad})
		+ $signed({1'b0, (COL_W+1)'(j_q)});
	assign rd_ok = cur_q.row_ok && !c_s[COL_W+1] && (c_s < $signed({1'b0, cur_q.width}));
	assign raddr = ADDR_W'(cur_q.tap_row * cur_q.width + (ADDR_W)'(c_s[COL_W:0]));
	assign waddr = q_head.addr;

	ppsc_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_store (
		.clk(clk),
		.we(q_pop && q_head.kind == CMD_SAMPLE),
		.waddr(waddr),
		.wdata(q_head.value),
		.raddr(raddr),
		.rdata(ram_rd)
	);

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		rd_en = 1'b0;
		unique case (state_q)
			BK_IDLE: if (q_not_empty) begin
				q_pop = 1'b1;
				if (q_head.kind == CMD_VWT) state_d = BK_WALK;
			end
			BK_WALK: begin
				rd_en = 1'b1;
				if (j_q + 1'b1 == cur_q.ksize) state_d = BK_ACC;
			end
			BK_ACC: if (drain_q == 3'd0 && !rd_v_s1 && !rd_v_s2 && !prod_v_s3)
				state_d = cur_q.last_tap ? BK_OUT : BK_IDLE;
			BK_OUT: if (!out_v_q || out_ready) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
			if (q_head.kind == CMD_HWT) rw_q[q_head.widx] <= q_head.value;
		end
		rd_ok_s1 <= rd_ok; j_s1 <= KIDX_W'(j_q);
		samp_s2 <= rd_ok_s1 ? $signed(ram_rd) : 16'sd0;
		wt_s2 <= rw_q[j_s1];
		prod_s3 <= samp_s2 * wt_s2;
		vprod_q <= rsum_q * cur_q.value;
	end

	always_comb begin
		acc_r = acc_q + 64'sd8388608;
		qv = 40'(acc_r >>> 24);
		if (qv > 40'sd32767) qv = 40'sd32767;
		else if (qv < -40'sd32768) qv = -40'sd32768;
	end

	assign out_valid = out_v_q;
	assign out_pixel = pix_q;
	assign out_last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE; j_q <= '0; rd_v_s1 <= 1'b0; rd_v_s2 <= 1'b0;
			prod_v_s3 <= 1'b0; rsum_q <= '0; acc_q <= '0; drain_q <= '0;
			out_v_q <= 1'b0; pix_q <= '0; last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= rd_en; rd_v_s2 <= rd_v_s1; prod_v_s3 <= rd_v_s2;
			if (state_q == BK_IDLE && q_pop && q_head.kind == CMD_VWT) begin
				j_q <= '0; rsum_q <= '0;
				if (q_head.first_tap) acc_q <= '0;
			end
			if (rd_en) j_q <= j_q + 1'b1;
			if (prod_v_s3) rsum_q <= rsum_q + 40'(prod_s3);
			// After the last product is summed: vertical product, then accumulate.
			if (state_q == BK_WALK && state_d == BK_ACC) drain_q <= 3'd5;
			else if (drain_q != 3'd0) drain_q <= drain_q - 1'b1;
			if (drain_q == 3'd1) acc_q <= acc_q + 64'(vprod_q);
			if (state_q == BK_OUT && (!out_v_q || out_ready)) begin
				out_v_q <= 1'b1; pix_q <= qv[15:0]; last_q <= cur_q.last_pixel;
			end else if (out_v_q && out_ready)
				out_v_q <= 1'b0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> state_q == BK_WALK)
		else $error("read issued outside walk");
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == BK_IDLE)
		else $error("pop while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_WALK |-> j_q < cur_q.ksize)
		else $error("tap count overrun");
endmodule

// ===== rtl/core/per_pixel_separable_convolution_top.sv =====
// ============================================================================
// per_pixel_separable_convolution_top - adaptive separable filter
// Loads one image plane, then filters it with a kernel given per pixel.
// ============================================================================
// Send the plane as opcode-0 requests in raster order, then per output
// pixel K horizontal then K vertical weights as opcode-1 requests.
// A request of the wrong phase is dropped. A horizontal weight is stored
// in the row weight table; a vertical weight walks the frame-store read
// port along the row, one multiply-accumulate per tap, and then drains the
// multiply pipeline (on the last tap of a pixel it also loads the output
// register). A four-deep command queue parts the classifying front from
// the execution unit, and an output register holds the finished pixel so
// new requests keep flowing. Write configuration only while idle; any
// write to width, height or kernel restarts the loading phase.
module per_pixel_separable_convolution_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [ppsc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ppsc_pkg::CFG_DATA_W-1:0] cfg_data,
	ppsc_stream_if.sink   in_ch,
	ppsc_stream_if.source out_ch
);
	import ppsc_pkg::*;

	cmd_t cmd, head;
	logic push, full, pop, not_empty;
	logic [15:0] pix;
	logic last;

	// Classify each request.
	ppsc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_op(in_ch.data[16]), .in_value(in_ch.data[15:0]),
		.cmd_push(push), .cmd(cmd), .q_full(full)
	);

	// Hold commands until the back end is free.
	ppsc_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(cmd), .full(full),
		.pop(pop), .not_empty(not_empty), .head(head)
	);

	// Execute writes and tap walks.
	ppsc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_not_empty(not_empty), .q_head(head), .q_pop(pop),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_pixel(pix), .out_last(last)
	);

	assign out_ch.data = {last, pix};
endmodule

// ===== tb/sv/tb.sv =====
// ============================================================================
// tb - regression bench for per_pixel_separable_convolution_top
// Loads small image planes, streams per-pixel kernels with random gaps and
// output stalls, and checks every filtered pixel against a local predictor.
// ============================================================================

class conv_scoreboard;

	typedef struct {
		logic signed [15:0] pixel;
		logic               last;
	} pixel_exp_t;

	pixel_exp_t         pixel_q[$];
	int                 errors;
	logic [8:0]         width_reg;
	logic [8:0]         height_reg;
	logic [3:0]         ksize_reg;
	logic signed [15:0] plane[int];
	logic signed [15:0] hweights[15];
	int                 load_pos;
	int                 col;
	int                 row;
	int                 wpos;
	longint             acc;
	bit                 computing;

	function new();
		width_reg  = 9'd256;
		height_reg = 9'd256;
		ksize_reg  = 4'd3;
		errors     = 0;
		restart();
	endfunction

	function void restart();
		load_pos  = 0;
		col       = 0;
		row       = 0;
		wpos      = 0;
		acc       = 0;
		computing = 0;
	endfunction

	function void write_reg(ppsc_pkg::cfg_reg_t idx, logic [8:0] val);
		case (idx)
			ppsc_pkg::REG_WIDTH:  width_reg  = val;
			ppsc_pkg::REG_HEIGHT: height_reg = val;
			ppsc_pkg::REG_KERNEL: ksize_reg  = val[3:0];
			default: ;
		endcase
		restart();
	endfunction

	function int clampi(int v, int hi);
		return (v < 1) ? 1 : (v > hi) ? hi : v;
	endfunction

	function longint row_sum(int r, int w, int h, int k);
		longint s;
		int     half;
		int     c;
		s    = 0;
		half = (k - 1) / 2;
		if (r < 0 || r >= h)
			return 0;
		for (int j = 0; j < k; j++) begin
			c = col - half + j;
			if (c >= 0 && c < w)
				s += longint'(plane[r * w + c]) * longint'(hweights[j]);
		end
		return s;
	endfunction

	// Advance the predictor by one accepted request.
	function void note_request(ppsc_pkg::opcode_t op, logic signed [15:0] val);
		int         w;
		int         h;
		int         k;
		longint     q;
		pixel_exp_t e;
		w = clampi(width_reg, ppsc_pkg::MAX_WIDTH);
		h = clampi(height_reg, ppsc_pkg::MAX_HEIGHT);
		k = clampi(ksize_reg, ppsc_pkg::MAX_KERNEL);
		if (!computing) begin
			if (op != ppsc_pkg::OP_SAMPLE)
				return;
			plane[load_pos] = val;
			load_pos++;
			if (load_pos >= w * h) begin
				computing = 1;
				col = 0; row = 0; wpos = 0; acc = 0;
			end
			return;
		end
		if (op != ppsc_pkg::OP_WEIGHT)
			return;
		if (wpos < k) begin
			hweights[wpos] = val;
			wpos++;
			return;
		end
		acc += row_sum(row - (k - 1) / 2 + (wpos - k), w, h, k) * longint'(val);
		wpos++;
		if (wpos < 2 * k)
			return;
		q = (acc + (longint'(1) << 23)) >>> 24;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		e.pixel = q[15:0];
		e.last  = (col + 1 >= w) && (row + 1 >= h);
		pixel_q.push_back(e);
		wpos = 0;
		acc  = 0;
		if (e.last)
			restart();
		else if (col + 1 >= w) begin
			col = 0;
			row++;
		end else
			col++;
	endfunction

	function void check_pixel(logic signed [15:0] px, logic last);
		pixel_exp_t e;
		if (pixel_q.size() == 0) begin
			$display("%0t: unexpected pixel %0d last %0b", $time, px, last);
			errors++;
			return;
		end
		e = pixel_q.pop_front();
		if (px !== e.pixel) begin
			$display("%0t: pixel_out expected %0d actual %0d", $time, e.pixel, px);
			errors++;
		end
		if (last !== e.last) begin
			$display("%0t: last_pixel expected %0b actual %0b", $time, e.last, last);
			errors++;
		end
	endfunction

	function int pending();
		return pixel_q.size();
	endfunction

endclass

module tb;

	import ppsc_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	ppsc_stream_if #(.W(17)) in_ch ();
	ppsc_stream_if #(.W(17)) out_ch ();

	per_pixel_separable_convolution_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	conv_scoreboard sb = new();

	// Gaps are suppressed during some planes so dense traffic is seen too.
	bit  no_gaps;
	int  cycles;
	int  accepted;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard limit: far above the slowest legal run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Check each accepted pixel on the rising edge.
	always @(posedge clk)
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_pixel(out_ch.data[15:0], out_ch.data[16]);

	// Sink: stall a random number of cycles before taking each pixel.
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 18);
			repeat (stall) @(negedge clk) out_ch.ready <= 1'b0;
			@(negedge clk) out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	task automatic send_request(opcode_t op, logic signed [15:0] val);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 18);
		repeat (gap) @(negedge clk) in_ch.valid <= 1'b0;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data  <= {op, val};
		do @(posedge clk); while (!in_ch.ready);
		sb.note_request(op, val);
		accepted++;
		@(negedge clk) in_ch.valid <= 1'b0;
	endtask

	// Hold until every pixel is back, then let dropped requests clear.
	task automatic drain();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic write_cfg(cfg_reg_t idx, logic [8:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	function automatic logic signed [15:0] rand_weight();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 65535));
			default: return 16'sd4096 - 16'($urandom_range(0, 8191));
		endcase
	endfunction

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// One plane: load, then filter up to stop_at pixels, with sprinkled noise.
	task automatic run_plane(int w, int h, int k, int stop_at);
		for (int i = 0; i < w * h; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_request(OP_WEIGHT, rand_weight());   // dropped during load
			send_request(OP_SAMPLE, rand_sample());
		end
		for (int p = 0; p < w * h && p < stop_at; p++)
			for (int t = 0; t < 2 * k; t++) begin
				if ($urandom_range(0, 19) == 0)
					send_request(OP_SAMPLE, rand_sample()); // dropped in compute
				send_request(OP_WEIGHT, rand_weight());
			end
	endtask

	initial begin
		int          w;
		int          h;
		int          k;
		logic [8:0]  wv;
		logic [8:0]  hv;
		logic [3:0]  kv;
		int          stop_at;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = REG_WIDTH;
		cfg_data     = '0;
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		no_gaps      = 1'b0;
		accepted     = 0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: 2x1 plane, K=3, extreme samples, padding at both edges,
		// wrong-phase requests dropped.
		write_cfg(REG_WIDTH, 9'd2);
		write_cfg(REG_HEIGHT, 9'd1);
		write_cfg(REG_KERNEL, 4'd3);
		send_request(OP_WEIGHT, 16'sh1000);
		send_request(OP_SAMPLE, 16'sh7FFF);
		send_request(OP_SAMPLE, 16'sh8000);
		send_request(OP_SAMPLE, 16'sh1234);
		repeat (3) send_request(OP_WEIGHT, 16'sh8000);
		repeat (3) send_request(OP_WEIGHT, 16'sh8000);
		repeat (3) send_request(OP_WEIGHT, 16'sh7FFF);
		repeat (3) send_request(OP_WEIGHT, 16'sh0000);
		send_request(OP_WEIGHT, 16'sh1000);
		send_request(OP_WEIGHT, 16'sh0000);
		drain();

		// Random planes; sizes mostly small, a few at the extremes.
		accepted = 0;
		while (accepted < 900) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 11))
				0: begin
					wv = 9'd256 + 9'($urandom_range(0, 255)); hv = 9'd0; kv = 4'd1;
				end
				1: begin wv = 9'd1; hv = 9'd511; kv = 4'd0; end
				2: begin wv = 9'd0; hv = 9'd1; kv = 4'd15; end
				default: begin
					wv = 9'($urandom_range(1, 6));
					hv = 9'($urandom_range(1, 5));
					kv = 4'($urandom_range(0, 15));
				end
			endcase
			write_cfg(REG_WIDTH, wv);
			write_cfg(REG_HEIGHT, hv);
			write_cfg(REG_KERNEL, kv);
			w = (wv < 1) ? 1 : (wv > MAX_WIDTH) ? MAX_WIDTH : wv;
			h = (hv < 1) ? 1 : (hv > MAX_HEIGHT) ? MAX_HEIGHT : hv;
			k = (kv < 1) ? 1 : kv;
			// Now and then abandon a plane part way; the next write restarts it.
			stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w * h) : w * h;
			run_plane(w, h, k, stop_at);
			drain();
		end

		drain();
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
